// ----- sv/scrs_pkg.sv -----
// ----------------------------------------------------------------------------
// scrs_pkg
// Shared types and constants for the SPI command register slave.
// ----------------------------------------------------------------------------
package scrs_pkg;

  localparam int unsigned ADC_BITS_DEF = 12;
  localparam int unsigned WORD_W       = 16;
  localparam int unsigned CMD_W        = 5;
  localparam int unsigned ENABLE_W     = 8;
  localparam int unsigned VALUE_W      = 32;

  // first word value past the command range
  localparam logic [WORD_W-1:0] CMD_LIMIT = 16'd19;

  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [VALUE_W-1:0] value_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_NONE         = 5'd0,
    CMD_SET_DUTY_A_H = 5'd1,
    CMD_SET_DUTY_A_L = 5'd2,
    CMD_SET_DUTY_B_H = 5'd3,
    CMD_SET_DUTY_B_L = 5'd4,
    CMD_SET_LED      = 5'd5,
    CMD_GET_DUTY_A_H = 5'd6,
    CMD_GET_DUTY_A_L = 5'd7,
    CMD_GET_DUTY_B_H = 5'd8,
    CMD_GET_DUTY_B_L = 5'd9,
    CMD_GET_LED      = 5'd10,
    CMD_SET_ENABLE   = 5'd11,
    CMD_GET_ENABLE   = 5'd12,
    CMD_GET_ADC_ONE  = 5'd13,
    CMD_GET_ADC_TWO  = 5'd14,
    CMD_SET_PERIOD_H = 5'd15,
    CMD_SET_PERIOD_L = 5'd16,
    CMD_GET_PERIOD_H = 5'd17,
    CMD_GET_PERIOD_L = 5'd18
  } cmd_t;

endpackage

// ----- sv/scrs_if.sv -----
// ----------------------------------------------------------------------------
// scrs_if
// Valid/ready channels: received SPI word in, reply and register state out.
// ----------------------------------------------------------------------------
interface scrs_in_if
  import scrs_pkg::*;
#(
  parameter int unsigned ADC_BITS = ADC_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic [WORD_W-1:0]   received_word;
  logic [ADC_BITS-1:0] adc_sample_one;
  logic [ADC_BITS-1:0] adc_sample_two;

  modport source (output valid, received_word, adc_sample_one, adc_sample_two,
                  input ready);
  modport sink   (input valid, received_word, adc_sample_one, adc_sample_two,
                  output ready);
endinterface

interface scrs_out_if
  import scrs_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [WORD_W-1:0]  reply_word;
  logic               enable_a;
  logic               enable_b;
  logic [VALUE_W-1:0] duty_a;
  logic [VALUE_W-1:0] duty_b;
  logic [WORD_W-1:0]  led_duty;
  logic [VALUE_W-1:0] pwm_period;

  modport source (output valid, reply_word, enable_a, enable_b, duty_a, duty_b,
                  led_duty, pwm_period, input ready);
  modport sink   (input valid, reply_word, enable_a, enable_b, duty_a, duty_b,
                  led_duty, pwm_period, output ready);
endinterface

// ----- sv/spi_command_register_slave.sv -----
// ----------------------------------------------------------------------------
// spi_command_register_slave
// Classifies received SPI words as commands or data and runs the register
// set/get protocol; the reply goes out with the committed register values.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake     Beat contents
// in_ch     in   valid/ready   received_word, adc_sample_one, adc_sample_two
// out_ch    out  valid/ready   reply_word, enable_a/b, duty_a/b, led_duty,
//                              pwm_period
//
// One beat per cycle while out_ch is not stalled; the result of a beat is on out_ch the cycle after it.
// The state registers double as the result register, so a new beat is taken
// whenever the result slot is empty or being drained in the same cycle.
// Reset clears the registers (expect_cmd_r is set); the command/data alternation
// restarts with the next word expected to be a command.
// ----------------------------------------------------------------------------
module spi_command_register_slave
  import scrs_pkg::*;
#(
  parameter int unsigned ADC_BITS = ADC_BITS_DEF
)(
  input  logic        clk,
  input  logic        rst_n,
  scrs_in_if.sink     in_ch,
  scrs_out_if.source  out_ch
);

  logic                began_r, began_nxt;
  logic                expect_cmd_r, expect_cmd_nxt;
  cmd_t                cur_cmd_r, cur_cmd_nxt;
  word_t               reply_r, reply_nxt;
  value_t              staged_a_r, staged_a_nxt;
  value_t              live_a_r, live_a_nxt;
  value_t              staged_b_r, staged_b_nxt;
  value_t              live_b_r, live_b_nxt;
  word_t               led_r, led_nxt;
  value_t              staged_per_r, staged_per_nxt;
  value_t              live_per_r, live_per_nxt;
  logic [ENABLE_W-1:0] enable_r, enable_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic  in_fire;
  logic  forced_data;
  logic  in_range;
  logic  is_cmd;
  word_t word;
  word_t adc_one;
  word_t adc_two;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign word        = in_ch.received_word;
  assign adc_one     = WORD_W'(in_ch.adc_sample_one);
  assign adc_two     = WORD_W'(in_ch.adc_sample_two);
  assign forced_data = began_r && !expect_cmd_r;
  assign in_range    = (word != '0) && (word < CMD_LIMIT);
  assign is_cmd      = !forced_data && in_range;

  always_comb begin
    began_nxt      = began_r;
    expect_cmd_nxt = expect_cmd_r;
    cur_cmd_nxt    = cur_cmd_r;
    reply_nxt      = reply_r;
    staged_a_nxt   = staged_a_r;
    live_a_nxt     = live_a_r;
    staged_b_nxt   = staged_b_r;
    live_b_nxt     = live_b_r;
    led_nxt        = led_r;
    staged_per_nxt = staged_per_r;
    live_per_nxt   = live_per_r;
    enable_nxt     = enable_r;
    out_valid_nxt  = out_valid_r;

    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (in_fire) begin
      out_valid_nxt = 1'b1;

      // classify: a word in the command range, when a command is due, latches a new command
      if (is_cmd) begin
        cur_cmd_nxt = cmd_t'(word[CMD_W-1:0]);
      end else if (!began_r) begin
        cur_cmd_nxt = CMD_NONE;
        reply_nxt   = '0;
      end

      unique case (cur_cmd_nxt)
        CMD_SET_DUTY_A_H: begin
          if (is_cmd) begin
            reply_nxt = WORD_W'(CMD_SET_DUTY_A_H);
          end else begin
            staged_a_nxt = {word, 16'h0000};
            reply_nxt    = '0;
          end
        end
        CMD_SET_DUTY_A_L: begin
          if (is_cmd) begin
            reply_nxt = WORD_W'(CMD_SET_DUTY_A_L);
          end else begin
            staged_a_nxt = staged_a_r | VALUE_W'(word);
            live_a_nxt   = staged_a_r | VALUE_W'(word);
            reply_nxt    = '0;
          end
        end
        CMD_SET_DUTY_B_H: begin
          if (is_cmd) begin
            reply_nxt = WORD_W'(CMD_SET_DUTY_B_H);
          end else begin
            staged_b_nxt = {word, 16'h0000};
            reply_nxt    = '0;
          end
        end
        CMD_SET_DUTY_B_L: begin
          if (is_cmd) begin
            reply_nxt = WORD_W'(CMD_SET_DUTY_B_L);
          end else begin
            staged_b_nxt = staged_b_r | VALUE_W'(word);
            live_b_nxt   = staged_b_r | VALUE_W'(word);
            reply_nxt    = '0;
          end
        end
        CMD_SET_LED: begin
          if (is_cmd) begin
            reply_nxt = WORD_W'(CMD_SET_LED);
          end else begin
            led_nxt   = word;
            reply_nxt = '0;
          end
        end
        CMD_GET_DUTY_A_H: reply_nxt = live_a_r[VALUE_W-1:WORD_W];
        CMD_GET_DUTY_A_L: reply_nxt = live_a_r[WORD_W-1:0];
        CMD_GET_DUTY_B_H: reply_nxt = live_b_r[VALUE_W-1:WORD_W];
        CMD_GET_DUTY_B_L: reply_nxt = live_b_r[WORD_W-1:0];
        CMD_GET_LED:      reply_nxt = led_r;
        CMD_SET_ENABLE: begin
          if (is_cmd) begin
            reply_nxt = WORD_W'(CMD_SET_ENABLE);
          end else begin
            enable_nxt = word[ENABLE_W-1:0];
            reply_nxt  = '0;
          end
        end
        CMD_GET_ENABLE:   reply_nxt = WORD_W'(enable_r);
        CMD_GET_ADC_ONE:  reply_nxt = adc_one;
        CMD_GET_ADC_TWO:  reply_nxt = adc_two;
        CMD_SET_PERIOD_H: begin
          if (is_cmd) begin
            reply_nxt = WORD_W'(CMD_SET_PERIOD_H);
          end else begin
            staged_per_nxt = {word, 16'h0000};
            reply_nxt      = '0;
          end
        end
        CMD_SET_PERIOD_L: begin
          if (is_cmd) begin
            reply_nxt = WORD_W'(CMD_SET_PERIOD_L);
          end else begin
            staged_per_nxt = staged_per_r | VALUE_W'(word);
            live_per_nxt   = staged_per_r | VALUE_W'(word);
            reply_nxt      = '0;
          end
        end
        CMD_GET_PERIOD_H: reply_nxt = live_per_r[VALUE_W-1:WORD_W];
        CMD_GET_PERIOD_L: reply_nxt = live_per_r[WORD_W-1:0];
        default: ; // no command: hold reply
      endcase

      began_nxt      = 1'b1;
      expect_cmd_nxt = !is_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      began_r      <= 1'b0;
      expect_cmd_r <= 1'b1;
      cur_cmd_r    <= CMD_NONE;
      reply_r      <= '0;
      staged_a_r   <= '0;
      live_a_r     <= '0;
      staged_b_r   <= '0;
      live_b_r     <= '0;
      led_r        <= '0;
      staged_per_r <= '0;
      live_per_r   <= '0;
      enable_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      began_r      <= began_nxt;
      expect_cmd_r <= expect_cmd_nxt;
      cur_cmd_r    <= cur_cmd_nxt;
      reply_r      <= reply_nxt;
      staged_a_r   <= staged_a_nxt;
      live_a_r     <= live_a_nxt;
      staged_b_r   <= staged_b_nxt;
      live_b_r     <= live_b_nxt;
      led_r        <= led_nxt;
      staged_per_r <= staged_per_nxt;
      live_per_r   <= live_per_nxt;
      enable_r     <= enable_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.reply_word = reply_r;
  assign out_ch.enable_a   = enable_r[0];
  assign out_ch.enable_b   = enable_r[1];
  assign out_ch.duty_a     = live_a_r;
  assign out_ch.duty_b     = live_b_r;
  assign out_ch.led_duty   = led_r;
  assign out_ch.pwm_period = live_per_r;

endmodule

// ----- dv/spi_command_register_slave_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spi_command_register_slave_checker
// Watches both channels, predicts the reply and register state for every
// accepted word, and compares each result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module spi_command_register_slave_checker
  import scrs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  scrs_in_if          in_ch,
  scrs_out_if         out_ch,
  output int unsigned mismatches,
  output int unsigned replies_owed
);

  typedef struct packed {
    word_t  reply;
    logic   en_a;
    logic   en_b;
    value_t duty_a;
    value_t duty_b;
    word_t  led;
    value_t period;
  } spi_result_t;

  // predicted register file of the slave
  logic                seen_first;
  logic                want_cmd;
  cmd_t                active_cmd;
  word_t               reply_hold;
  value_t              a_stage;
  value_t              a_live;
  value_t              b_stage;
  value_t              b_live;
  word_t               led_live;
  value_t              per_stage;
  value_t              per_live;
  logic [ENABLE_W-1:0] enables;

  spi_result_t reply_q[$];
  int unsigned fail_total = 0;

  assign mismatches   = fail_total;
  assign replies_owed = reply_q.size();

  task automatic log_mismatch(input string msg);
    if (fail_total < 60) $display("[%0t] MISMATCH %s", $time, msg);
    fail_total++;
  endtask

  task automatic check_field(input string name, input value_t got, input value_t want);
    if (got !== want)
      log_mismatch($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  function automatic spi_result_t run_spi_word(input word_t w, input word_t adc1,
                                               input word_t adc2);
    logic        is_cmd;
    spi_result_t r;
    if (seen_first && !want_cmd) begin
      is_cmd = 1'b0;
    end else if (w != '0 && w < CMD_LIMIT) begin
      active_cmd = cmd_t'(w[CMD_W-1:0]);
      is_cmd     = 1'b1;
    end else begin
      is_cmd = 1'b0;
      // data ahead of the first command clears the command and the reply
      if (!seen_first) begin
        active_cmd = CMD_NONE;
        reply_hold = '0;
      end
    end

    case (active_cmd)
      CMD_SET_DUTY_A_H, CMD_SET_DUTY_A_L, CMD_SET_DUTY_B_H, CMD_SET_DUTY_B_L,
      CMD_SET_LED, CMD_SET_ENABLE, CMD_SET_PERIOD_H, CMD_SET_PERIOD_L: begin
        if (is_cmd) begin
          reply_hold = word_t'(active_cmd);
        end else begin
          reply_hold = '0;
          case (active_cmd)
            CMD_SET_DUTY_A_H: a_stage = {w, 16'h0000};
            CMD_SET_DUTY_A_L: begin
              a_stage = a_stage | value_t'(w);
              a_live  = a_stage;
            end
            CMD_SET_DUTY_B_H: b_stage = {w, 16'h0000};
            CMD_SET_DUTY_B_L: begin
              b_stage = b_stage | value_t'(w);
              b_live  = b_stage;
            end
            CMD_SET_LED:      led_live = w;
            CMD_SET_ENABLE:   enables = w[ENABLE_W-1:0];
            CMD_SET_PERIOD_H: per_stage = {w, 16'h0000};
            default: begin
              per_stage = per_stage | value_t'(w);
              per_live  = per_stage;
            end
          endcase
        end
      end
      CMD_GET_DUTY_A_H: reply_hold = a_live[31:16];
      CMD_GET_DUTY_A_L: reply_hold = a_live[15:0];
      CMD_GET_DUTY_B_H: reply_hold = b_live[31:16];
      CMD_GET_DUTY_B_L: reply_hold = b_live[15:0];
      CMD_GET_LED:      reply_hold = led_live;
      CMD_GET_ENABLE:   reply_hold = word_t'(enables);
      CMD_GET_ADC_ONE:  reply_hold = adc1;
      CMD_GET_ADC_TWO:  reply_hold = adc2;
      CMD_GET_PERIOD_H: reply_hold = per_live[31:16];
      CMD_GET_PERIOD_L: reply_hold = per_live[15:0];
      default: ;  // no command yet: hold the reply
    endcase

    seen_first = 1'b1;
    want_cmd   = !is_cmd;

    r.reply  = reply_hold;
    r.en_a   = enables[0];
    r.en_b   = enables[1];
    r.duty_a = a_live;
    r.duty_b = b_live;
    r.led    = led_live;
    r.period = per_live;
    return r;
  endfunction

  always @(posedge clk) begin
    spi_result_t got;
    spi_result_t want;
    if (!rst_n) begin
      seen_first = 1'b0;
      want_cmd   = 1'b1;
      active_cmd = CMD_NONE;
      reply_hold = '0;
      a_stage    = '0;
      a_live     = '0;
      b_stage    = '0;
      b_live     = '0;
      led_live   = '0;
      per_stage  = '0;
      per_live   = '0;
      enables    = '0;
      reply_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.reply  = out_ch.reply_word;
        got.en_a   = out_ch.enable_a;
        got.en_b   = out_ch.enable_b;
        got.duty_a = out_ch.duty_a;
        got.duty_b = out_ch.duty_b;
        got.led    = out_ch.led_duty;
        got.period = out_ch.pwm_period;
        if (reply_q.size() == 0) begin
          log_mismatch($sformatf("result beat with no word pending, reply 0x%0h",
                                 got.reply));
        end else begin
          want = reply_q.pop_front();
          check_field("reply_word", value_t'(got.reply), value_t'(want.reply));
          check_field("enable_a", value_t'(got.en_a), value_t'(want.en_a));
          check_field("enable_b", value_t'(got.en_b), value_t'(want.en_b));
          check_field("duty_a", got.duty_a, want.duty_a);
          check_field("duty_b", got.duty_b, want.duty_b);
          check_field("led_duty", value_t'(got.led), value_t'(want.led));
          check_field("pwm_period", got.period, want.period);
        end
      end
      if (in_ch.valid && in_ch.ready)
        reply_q.push_back(run_spi_word(in_ch.received_word,
                                       word_t'(in_ch.adc_sample_one),
                                       word_t'(in_ch.adc_sample_two)));
    end
  end

endmodule

// ----- dv/spi_command_register_slave_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spi_command_register_slave_tb
// Drives SPI words through the slave: directed command/data pairs for every
// command and the classification corner cases, then random pairs, set
// sequences and stray words, with random gaps and back-pressure on both sides.
// ----------------------------------------------------------------------------
module spi_command_register_slave_tb;
  import scrs_pkg::*;

  localparam int unsigned STALL_LIMIT = 500;
  localparam int unsigned PHASE_WORDS = 200;

  logic        clk;
  logic        rst_n;
  logic        calm;
  int unsigned fail_total;
  int unsigned owed;
  int unsigned sent_words = 0;
  int unsigned idle_cycles = 0;

  scrs_in_if #(.ADC_BITS(ADC_BITS_DEF)) in_ch ();
  scrs_out_if                           out_ch ();

  spi_command_register_slave #(.ADC_BITS(ADC_BITS_DEF)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  spi_command_register_slave_checker reply_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .mismatches   (fail_total),
    .replies_owed (owed)
  );

  always #5 clk = ~clk;

  function automatic int unsigned pick_gap();
    if (calm || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 13);
  endfunction

  function automatic logic [ADC_BITS_DEF-1:0] pick_adc();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return ADC_BITS_DEF'($urandom_range(0, (1 << ADC_BITS_DEF) - 1));
    endcase
  endfunction

  function automatic word_t pick_data();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return word_t'($urandom_range(1, 18));
      default: return word_t'($urandom);
    endcase
  endfunction

  task automatic send_word(input word_t w);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.received_word  <= w;
    in_ch.adc_sample_one <= pick_adc();
    in_ch.adc_sample_two <= pick_adc();
    do @(posedge clk); while (!in_ch.ready);
    sent_words++;
  endtask

  task automatic send_pair(input cmd_t c, input word_t d);
    send_word(word_t'(c));
    send_word(d);
  endtask

  // hold the sender off until every reply is back
  task automatic drain_replies();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (owed != 0) @(posedge clk);
  endtask

  task automatic random_step();
    cmd_t c;
    case ($urandom_range(0, 9))
      0: send_word(word_t'($urandom));
      1: send_word(word_t'($urandom_range(0, 20)));
      2, 3: begin
        case ($urandom_range(0, 2))
          0:       c = CMD_SET_DUTY_A_H;
          1:       c = CMD_SET_DUTY_B_H;
          default: c = CMD_SET_PERIOD_H;
        endcase
        send_pair(c, pick_data());
        send_pair(cmd_t'(c + 1), pick_data());
      end
      default: send_pair(cmd_t'($urandom_range(1, 18)), pick_data());
    endcase
  endtask

  // sink side: random stall before each result beat
  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("spi_command_register_slave verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned target;
    clk                  = 1'b0;
    rst_n                = 1'b0;
    calm                 = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.received_word  = '0;
    in_ch.adc_sample_one = '0;
    in_ch.adc_sample_two = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // data ahead of any command, then a stray word with no command active
    send_word(16'h0000);
    send_word(16'hFFFF);
    // low half with nothing staged, then full-scale duty A
    send_pair(CMD_SET_DUTY_A_L, 16'h1234);
    send_pair(CMD_SET_DUTY_A_H, 16'hFFFF);
    send_pair(CMD_SET_DUTY_A_L, 16'hFFFF);
    send_pair(CMD_GET_DUTY_A_H, 16'h0000);
    // out-of-range word where a command is due reruns the last command
    send_word(word_t'(CMD_LIMIT));
    send_word(16'h0000);
    send_pair(CMD_SET_ENABLE, 16'hFF03);
    // walk every command, data alternating between 16'hFFFF and 16'h0012
    for (int i = 1; i <= 18; i++)
      send_pair(cmd_t'(i), (i % 2 == 0) ? 16'hFFFF : 16'h0012);
    send_pair(CMD_SET_ENABLE, 16'h0000);
    drain_replies();

    for (int phase = 0; phase < 4; phase++) begin
      calm   = (phase == 2);
      target = sent_words + PHASE_WORDS;
      while (sent_words < target) random_step();
      drain_replies();
    end
    calm = 1'b0;

    repeat (4) @(posedge clk);
    if (fail_total == 0)
      $display("spi_command_register_slave verification clean");
    else
      $display("spi_command_register_slave verification failed");
    $finish;
  end

endmodule
